[sv/pras_pkg.sv]
`default_nettype none

package pras_pkg;

  // Number format: signed fixed point, DATA_W bits with FRAC_W fraction bits.
  localparam int DATA_W = 48;
  localparam int FRAC_W = 24;

  // Multiplier operands are split in halves of HALF_W bits.
  localparam int HALF_W = (DATA_W + 1) / 2;
  localparam int MAG_W  = 2 * HALF_W;
  localparam int PROD_W = 4 * HALF_W;
  localparam int MUL_LAT = 4;

  // Divider: DIV_STEP quotient bits per stage. DATA_W must be a multiple of it.
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = DATA_W / DIV_STEP;
  localparam int DIV_LAT    = DIV_STAGES + 3;

  // Configuration port.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;
  localparam int SIGMA_W    = DATA_W - 1;
  localparam logic [SIGMA_W-1:0] SIGMA_RESET = SIGMA_W'(17);
  localparam logic [CFG_ADDR_W-4:0] REG_SIGMA = '0;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [2:0] flag_t;

  localparam data_t MAX_V = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t MIN_V = {1'b1, {(DATA_W-1){1'b0}}};
  localparam data_t ONE_Q = {{(DATA_W-FRAC_W-1){1'b0}}, 1'b1, {FRAC_W{1'b0}}};

  localparam flag_t FLAG_SOFT_LO = -3'sd2;
  localparam flag_t FLAG_LOWER   = -3'sd1;
  localparam flag_t FLAG_NONE    = 3'sd0;
  localparam flag_t FLAG_UPPER   = 3'sd1;
  localparam flag_t FLAG_SOFT_HI = 3'sd2;

  typedef enum logic [2:0] {
    KIND_NONE      = 3'd0,
    KIND_L1L2      = 3'd1,
    KIND_HUBER     = 3'd2,
    KIND_GROUP_L2  = 3'd3,
    KIND_GROUP_INF = 3'd4
  } penalty_kind_t;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_GROUP,
    CLS_SMOOTH_L2,
    CLS_SMOOTH_HUB,
    CLS_PIN_L1,
    CLS_PIN_HUB,
    CLS_LOWER,
    CLS_UPPER
  } row_class_t;

  // Per-row values that travel beside the divider.
  typedef struct packed {
    row_class_t cls;
    logic       above;
    data_t      rhs_base;
    data_t      diag_base;
    data_t      fix_val;
    logic       sat;
  } row_side_t;

  // Magnitude of a signed value; the most negative value gives 2^(DATA_W-1).
  function automatic logic [DATA_W-1:0] mag_f(data_t x);
    logic [DATA_W-1:0] ux;
    ux = x;
    return ux[DATA_W-1] ? (~ux) + DATA_W'(1) : ux;
  endfunction

endpackage

`default_nettype wire

[sv/pras_in_if.sv]
`default_nettype none

interface pras_in_if;
  import pras_pkg::*;

  logic       valid;
  logic       ready;
  data_t      z_value;
  data_t      dual_value;
  data_t      lower_bound;
  data_t      upper_bound;
  logic [2:0] penalty_kind;
  data_t      alpha_one;
  data_t      alpha_two;
  data_t      huber_delta;

  modport source (
    output valid, z_value, dual_value, lower_bound, upper_bound, penalty_kind,
    output alpha_one, alpha_two, huber_delta,
    input  ready
  );

  modport sink (
    input  valid, z_value, dual_value, lower_bound, upper_bound, penalty_kind,
    input  alpha_one, alpha_two, huber_delta,
    output ready
  );
endinterface

`default_nettype wire

[sv/pras_out_if.sv]
`default_nettype none

interface pras_out_if;
  import pras_pkg::*;

  logic  valid;
  logic  ready;
  flag_t row_flag;
  data_t kkt_diagonal;
  data_t kkt_exact_diagonal;
  data_t rhs_limit;
  data_t fixed_dual;
  logic  saturated;

  modport source (
    output valid, row_flag, kkt_diagonal, kkt_exact_diagonal, rhs_limit, fixed_dual,
    output saturated,
    input  ready
  );

  modport sink (
    input  valid, row_flag, kkt_diagonal, kkt_exact_diagonal, rhs_limit, fixed_dual,
    input  saturated,
    output ready
  );
endinterface

`default_nettype wire

[sv/pras_div.sv]
`default_nettype none

// Pipelined restoring divider: quo = num * 2^FRAC_W / den, truncated toward
// zero and saturated. All stages advance only while en is high.
module pras_div (
  input  logic           clk,
  input  logic           en,
  input  pras_pkg::data_t num_i,
  input  pras_pkg::data_t den_i,
  output pras_pkg::data_t quo_o,
  output logic           sat_o
);
  import pras_pkg::*;

  typedef struct packed {
    logic neg;
    logic num_neg;
    logic num_zero;
    logic den_zero;
    logic ovf;
  } div_flag_t;

  // Operand magnitudes and signs.
  logic [DATA_W-1:0] num_mag_r;
  logic [DATA_W-1:0] den_mag_r;
  logic              neg_r;
  logic              num_neg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      num_mag_r <= mag_f(num_i);
      den_mag_r <= mag_f(den_i);
      neg_r     <= num_i[DATA_W-1] ^ den_i[DATA_W-1];
      num_neg_r <= num_i[DATA_W-1];
    end
  end

  // The shifted dividend splits into a high part, which must stay below the
  // divisor for the quotient to fit, and low bits fed in one per step.
  logic [DATA_W+FRAC_W-1:0] dvd_full;
  logic [DATA_W-1:0]        dvd_hi;

  assign dvd_full = {num_mag_r, {FRAC_W{1'b0}}};
  assign dvd_hi   = DATA_W'(dvd_full[DATA_W+FRAC_W-1:DATA_W]);

  logic [DATA_W-1:0] rem_r  [0:DIV_STAGES];
  logic [DATA_W-1:0] bits_r [0:DIV_STAGES];
  logic [DATA_W-1:0] quo_r  [0:DIV_STAGES];
  logic [DATA_W-1:0] den_r  [0:DIV_STAGES];
  div_flag_t         flg_r  [0:DIV_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]          <= dvd_hi;
      bits_r[0]         <= dvd_full[DATA_W-1:0];
      quo_r[0]          <= '0;
      den_r[0]          <= den_mag_r;
      flg_r[0].neg      <= neg_r;
      flg_r[0].num_neg  <= num_neg_r;
      flg_r[0].num_zero <= (num_mag_r == '0);
      flg_r[0].den_zero <= (den_mag_r == '0);
      flg_r[0].ovf      <= (dvd_hi >= den_mag_r);
    end
  end

  // Quotient stages, DIV_STEP restoring steps each.
  logic [DATA_W-1:0] rem_nxt  [1:DIV_STAGES];
  logic [DATA_W-1:0] bits_nxt [1:DIV_STAGES];
  logic [DATA_W-1:0] quo_nxt  [1:DIV_STAGES];

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_step
    always_comb begin
      logic [DATA_W:0]   trial;
      logic [DATA_W-1:0] rem;
      logic [DATA_W-1:0] bits;
      logic [DATA_W-1:0] quo;
      rem  = rem_r[k-1];
      bits = bits_r[k-1];
      quo  = quo_r[k-1];
      for (int j = 0; j < DIV_STEP; j++) begin
        trial = {rem, bits[DATA_W-1]};
        bits  = {bits[DATA_W-2:0], 1'b0};
        if (trial >= {1'b0, den_r[k-1]}) begin
          trial = trial - {1'b0, den_r[k-1]};
          quo   = {quo[DATA_W-2:0], 1'b1};
        end else begin
          quo   = {quo[DATA_W-2:0], 1'b0};
        end
        rem = trial[DATA_W-1:0];
      end
      rem_nxt[k]  = rem;
      bits_nxt[k] = bits;
      quo_nxt[k]  = quo;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt[k];
        bits_r[k] <= bits_nxt[k];
        quo_r[k]  <= quo_nxt[k];
        den_r[k]  <= den_r[k-1];
        flg_r[k]  <= flg_r[k-1];
      end
    end
  end

  // Saturation, division by zero and sign.
  logic [DATA_W-1:0] q_fin;
  div_flag_t         f_fin;
  logic              too_big;
  data_t             res_nxt;
  logic              sat_nxt;
  data_t             res_r;
  logic              sat_r;

  assign q_fin = quo_r[DIV_STAGES];
  assign f_fin = flg_r[DIV_STAGES];

  always_comb begin
    too_big = q_fin[DATA_W-1] && (!f_fin.neg || (q_fin[DATA_W-2:0] != '0));
    if (f_fin.den_zero) begin
      sat_nxt = 1'b1;
      res_nxt = f_fin.num_zero ? '0 : (f_fin.num_neg ? MIN_V : MAX_V);
    end else if (f_fin.ovf || too_big) begin
      sat_nxt = 1'b1;
      res_nxt = f_fin.neg ? MIN_V : MAX_V;
    end else begin
      sat_nxt = 1'b0;
      res_nxt = f_fin.neg ? data_t'((~q_fin) + DATA_W'(1)) : data_t'(q_fin);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign quo_o = res_r;
  assign sat_o = sat_r;

endmodule

`default_nettype wire

[sv/polish_row_active_set_classifier_top.sv]
`default_nettype none

// Channel   Port          Dir   Handshake      Beat
// rows      in_row        in    valid/ready    one constraint row
// results   out_res       out   valid/ready    one classified row
// config    psel..pready  in    APB, 64 bit    sigma at byte address 0
//
// One row enters per cycle while no result is stalled on out_res; results
// pass through the two-bit-per-stage quotient pipelines.
// rst_n is synchronous and clears the valid bits and sigma (to 17).
// A stalled result freezes the whole pipeline, so in_row.ready drops only
// while a finished result waits on out_res.
module polish_row_active_set_classifier_top (
  input  logic                                clk,
  input  logic                                rst_n,
  pras_in_if.sink                             in_row,
  pras_out_if.source                          out_res,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pras_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [pras_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [pras_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import pras_pkg::*;

  // Configuration register.
  logic [SIGMA_W-1:0] sigma_r;
  logic               sel_sigma;

  assign pready    = 1'b1;
  assign sel_sigma = (paddr[CFG_ADDR_W-1:3] == REG_SIGMA);
  assign prdata    = sel_sigma ? CFG_DATA_W'(sigma_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r <= SIGMA_RESET;
    end else if (psel && penable && pwrite && pready && sel_sigma) begin
      sigma_r <= pwdata[SIGMA_W-1:0];
    end
  end

  // Pipeline advances unless a finished result is stalled.
  logic en;
  logic out_valid_r;

  assign en           = !out_valid_r || out_res.ready;
  assign in_row.ready = en;

  // Stage A: input registers.
  logic       va_r;
  data_t      a_z_r, a_y_r, a_l_r, a_u_r, a_a1_r, a_a2_r, a_dl_r;
  logic [2:0] a_kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_row.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_z_r    <= in_row.z_value;
      a_y_r    <= in_row.dual_value;
      a_l_r    <= in_row.lower_bound;
      a_u_r    <= in_row.upper_bound;
      a_kind_r <= in_row.penalty_kind;
      a_a1_r   <= in_row.alpha_one;
      a_a2_r   <= in_row.alpha_two;
      a_dl_r   <= in_row.huber_delta;
    end
  end

  // Stage B: clamp, distance outside the bounds, activity compares.
  data_t                  clamp_lo, clamp_v;
  logic signed [DATA_W:0] s_wide, zy_sum;
  logic                   s_ovf;
  data_t                  s_val;

  always_comb begin
    clamp_lo = (a_z_r < a_l_r) ? a_l_r : a_z_r;
    clamp_v  = (clamp_lo > a_u_r) ? a_u_r : clamp_lo;
    s_wide   = $signed({a_z_r[DATA_W-1], a_z_r}) - $signed({clamp_v[DATA_W-1], clamp_v});
    s_ovf    = s_wide[DATA_W] != s_wide[DATA_W-1];
    s_val    = s_ovf ? (s_wide[DATA_W] ? MIN_V : MAX_V) : data_t'(s_wide[DATA_W-1:0]);
    zy_sum   = $signed({a_z_r[DATA_W-1], a_z_r}) + $signed({a_y_r[DATA_W-1], a_y_r});
  end

  logic       vb_r;
  data_t      b_s_r, b_y_r, b_l_r, b_u_r, b_a1_r, b_a2_r, b_dl_r;
  logic [2:0] b_kind_r;
  logic       b_ssat_r, b_lt_l_r, b_gt_u_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_s_r    <= s_val;
      b_ssat_r <= s_ovf;
      b_lt_l_r <= zy_sum < $signed({a_l_r[DATA_W-1], a_l_r});
      b_gt_u_r <= zy_sum > $signed({a_u_r[DATA_W-1], a_u_r});
      b_y_r    <= a_y_r;
      b_l_r    <= a_l_r;
      b_u_r    <= a_u_r;
      b_a1_r   <= a_a1_r;
      b_a2_r   <= a_a2_r;
      b_dl_r   <= a_dl_r;
      b_kind_r <= a_kind_r;
    end
  end

  // Stage C: classify the row and pick operands for the divider and multiplier.
  logic       grp, soft_out, above, a2_pos, dl_ok, lower, upper, neg_a1_sat;
  row_class_t cls;
  row_side_t  side_nxt;
  data_t      divb_den, neg_a1;

  always_comb begin
    grp      = 1'b0;
    soft_out = 1'b0;
    case (b_kind_r)
      KIND_GROUP_L2, KIND_GROUP_INF: grp = 1'b1;
      KIND_L1L2, KIND_HUBER:         soft_out = (b_s_r != '0);
      default:                       soft_out = 1'b0;
    endcase
    above  = !b_s_r[DATA_W-1];
    a2_pos = !b_a2_r[DATA_W-1] && (b_a2_r != '0);
    dl_ok  = !b_dl_r[DATA_W-1] && (mag_f(b_s_r) <= $unsigned(b_dl_r));
    lower  = ((b_l_r != MIN_V) && b_lt_l_r) || (b_l_r == b_u_r);
    upper  = (b_u_r != MAX_V) && b_gt_u_r;

    if (grp) begin
      cls = CLS_GROUP;
    end else if (soft_out) begin
      if (b_kind_r == KIND_L1L2 && a2_pos) begin
        cls = CLS_SMOOTH_L2;
      end else if (b_kind_r == KIND_HUBER && dl_ok) begin
        cls = CLS_SMOOTH_HUB;
      end else if (b_kind_r == KIND_L1L2) begin
        cls = CLS_PIN_L1;
      end else begin
        cls = CLS_PIN_HUB;
      end
    end else if (lower) begin
      cls = CLS_LOWER;
    end else if (upper) begin
      cls = CLS_UPPER;
    end else begin
      cls = CLS_NONE;
    end

    neg_a1_sat = (b_a1_r == MIN_V);
    neg_a1     = neg_a1_sat ? MAX_V : -b_a1_r;

    side_nxt.cls       = cls;
    side_nxt.above     = above;
    side_nxt.sat       = b_ssat_r;
    side_nxt.rhs_base  = '0;
    side_nxt.diag_base = '0;
    side_nxt.fix_val   = '0;
    case (cls)
      CLS_GROUP: side_nxt.fix_val = b_y_r;
      CLS_SMOOTH_L2: begin
        side_nxt.rhs_base  = above ? b_u_r : b_l_r;
        side_nxt.diag_base = b_a2_r;
      end
      CLS_SMOOTH_HUB: begin
        side_nxt.rhs_base  = above ? b_u_r : b_l_r;
        side_nxt.diag_base = b_a1_r;
      end
      CLS_PIN_L1: begin
        side_nxt.fix_val = above ? b_a1_r : neg_a1;
        side_nxt.sat     = b_ssat_r || (!above && neg_a1_sat);
      end
      CLS_LOWER: side_nxt.rhs_base = b_l_r;
      CLS_UPPER: side_nxt.rhs_base = b_u_r;
      default:   side_nxt.rhs_base = '0;
    endcase

    case (cls)
      CLS_SMOOTH_L2:  divb_den = b_a2_r;
      CLS_SMOOTH_HUB: divb_den = b_a1_r;
      default:        divb_den = data_t'({1'b0, sigma_r});
    endcase
  end

  logic      vc_r;
  row_side_t c_side_r;
  data_t     c_a1_r, c_a2_r, c_dl_r, c_divb_r;
  logic      c_mflip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_side_r  <= side_nxt;
      c_a1_r    <= b_a1_r;
      c_a2_r    <= b_a2_r;
      c_dl_r    <= b_dl_r;
      c_divb_r  <= divb_den;
      c_mflip_r <= !above;
    end
  end

  // Dividers: alpha_one / alpha_two, and one over the selected weight.
  data_t diva_q, divb_q;
  logic  diva_sat, divb_sat;

  pras_div u_div_ratio (
    .clk   (clk),
    .en    (en),
    .num_i (c_a1_r),
    .den_i (c_a2_r),
    .quo_o (diva_q),
    .sat_o (diva_sat)
  );

  pras_div u_div_recip (
    .clk   (clk),
    .en    (en),
    .num_i (ONE_Q),
    .den_i (c_divb_r),
    .quo_o (divb_q),
    .sat_o (divb_sat)
  );

  // Multiplier for the pinned Huber dual: four half-width products, sum, trim.
  logic [MAG_W-1:0]  mua_r, mub_r;
  logic              mneg0_r, mneg1_r, mneg2_r;
  logic [MAG_W-1:0]  pll_r, plh_r, phl_r, phh_r;
  logic [PROD_W-1:0] mp_r;
  logic [DATA_W-1:0] mlo;
  logic              mover;
  data_t             mres_r;
  logic              msat_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mua_r   <= MAG_W'(mag_f(c_a1_r));
      mub_r   <= MAG_W'(mag_f(c_dl_r));
      mneg0_r <= (c_a1_r[DATA_W-1] ^ c_dl_r[DATA_W-1]) ^ c_mflip_r;

      pll_r   <= mua_r[HALF_W-1:0] * mub_r[HALF_W-1:0];
      plh_r   <= mua_r[HALF_W-1:0] * mub_r[MAG_W-1:HALF_W];
      phl_r   <= mua_r[MAG_W-1:HALF_W] * mub_r[HALF_W-1:0];
      phh_r   <= mua_r[MAG_W-1:HALF_W] * mub_r[MAG_W-1:HALF_W];
      mneg1_r <= mneg0_r;

      mp_r    <= (PROD_W'(phh_r) << MAG_W) + (PROD_W'(plh_r) << HALF_W)
               + (PROD_W'(phl_r) << HALF_W) + PROD_W'(pll_r);
      mneg2_r <= mneg1_r;

      msat_r  <= mover;
      mres_r  <= mover ? (mneg2_r ? MIN_V : MAX_V)
                       : (mneg2_r ? data_t'((~mlo) + DATA_W'(1)) : data_t'(mlo));
    end
  end

  always_comb begin
    mlo   = mp_r[DATA_W+FRAC_W-1:FRAC_W];
    mover = (mp_r[PROD_W-1:DATA_W+FRAC_W] != '0) ||
            (mlo[DATA_W-1] && (!mneg2_r || (mlo[DATA_W-2:0] != '0)));
  end

  // Side values wait for the dividers; the product joins after MUL_LAT stages.
  row_side_t sd_r  [1:DIV_LAT];
  logic      vld_r [1:DIV_LAT];
  row_side_t sd_nxt[1:DIV_LAT];

  for (genvar j = 1; j <= DIV_LAT; j++) begin : g_side
    always_comb begin
      sd_nxt[j] = (j == 1) ? c_side_r : sd_r[(j == 1) ? 1 : j-1];
      if (j == MUL_LAT + 1 && sd_nxt[j].cls == CLS_PIN_HUB) begin
        sd_nxt[j].fix_val = mres_r;
        sd_nxt[j].sat     = sd_nxt[j].sat || msat_r;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= (j == 1) ? vc_r : vld_r[(j == 1) ? 1 : j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd_r[j] <= sd_nxt[j];
      end
    end
  end

  // Output stage: assemble the result beat.
  row_side_t              fin;
  logic signed [DATA_W:0] rhs_wide;
  logic                   rhs_ovf;
  flag_t                  flag_nxt;
  data_t                  diag_nxt, exact_nxt, rhs_nxt;
  logic                   sat_nxt;

  assign fin = sd_r[DIV_LAT];

  always_comb begin
    rhs_wide  = fin.above
              ? $signed({fin.rhs_base[DATA_W-1], fin.rhs_base}) - $signed({diva_q[DATA_W-1], diva_q})
              : $signed({fin.rhs_base[DATA_W-1], fin.rhs_base}) + $signed({diva_q[DATA_W-1], diva_q});
    rhs_ovf   = rhs_wide[DATA_W] != rhs_wide[DATA_W-1];
    flag_nxt  = FLAG_NONE;
    diag_nxt  = '0;
    exact_nxt = '0;
    rhs_nxt   = '0;
    sat_nxt   = fin.sat;
    case (fin.cls)
      CLS_SMOOTH_L2: begin
        flag_nxt  = fin.above ? FLAG_SOFT_HI : FLAG_SOFT_LO;
        diag_nxt  = fin.diag_base;
        exact_nxt = divb_q;
        rhs_nxt   = rhs_ovf ? (rhs_wide[DATA_W] ? MIN_V : MAX_V)
                            : data_t'(rhs_wide[DATA_W-1:0]);
        sat_nxt   = fin.sat || diva_sat || divb_sat || rhs_ovf;
      end
      CLS_SMOOTH_HUB: begin
        flag_nxt  = fin.above ? FLAG_SOFT_HI : FLAG_SOFT_LO;
        diag_nxt  = fin.diag_base;
        exact_nxt = divb_q;
        rhs_nxt   = fin.rhs_base;
        sat_nxt   = fin.sat || divb_sat;
      end
      CLS_LOWER: begin
        flag_nxt = FLAG_LOWER;
        diag_nxt = divb_q;
        rhs_nxt  = fin.rhs_base;
        sat_nxt  = fin.sat || divb_sat;
      end
      CLS_UPPER: begin
        flag_nxt = FLAG_UPPER;
        diag_nxt = divb_q;
        rhs_nxt  = fin.rhs_base;
        sat_nxt  = fin.sat || divb_sat;
      end
      default: flag_nxt = FLAG_NONE;
    endcase
  end

  flag_t out_flag_r;
  data_t out_diag_r, out_exact_r, out_rhs_r, out_fix_r;
  logic  out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[DIV_LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_flag_r  <= flag_nxt;
      out_diag_r  <= diag_nxt;
      out_exact_r <= exact_nxt;
      out_rhs_r   <= rhs_nxt;
      out_fix_r   <= fin.fix_val;
      out_sat_r   <= sat_nxt;
    end
  end

  assign out_res.valid              = out_valid_r;
  assign out_res.row_flag           = out_flag_r;
  assign out_res.kkt_diagonal       = out_diag_r;
  assign out_res.kkt_exact_diagonal = out_exact_r;
  assign out_res.rhs_limit          = out_rhs_r;
  assign out_res.fixed_dual         = out_fix_r;
  assign out_res.saturated          = out_sat_r;

`ifndef ASSERT_OFF
  // A row outside the reduced set carries no diagonal and no bound.
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.row_flag == FLAG_NONE |->
      out_res.kkt_diagonal == '0 && out_res.kkt_exact_diagonal == '0 &&
      out_res.rhs_limit == '0)
    else $error("inactive row has nonzero diagonal or bound");

  // Hard active rows have no exact diagonal and no pinned dual.
  a_hard_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && (out_res.row_flag == FLAG_LOWER || out_res.row_flag == FLAG_UPPER) |->
      out_res.kkt_exact_diagonal == '0 && out_res.fixed_dual == '0)
    else $error("hard active row carries soft fields");

  // Input backpressure only comes from a stalled result.
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_row.ready |-> out_res.valid && !out_res.ready)
    else $error("input stalled without an output stall");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_res.valid)
    else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire
